### hw/rtl/sidalloc_pkg.sv
// ----------------------------------------------------------------------------
// sidalloc_pkg
// Shared types and constants for the round-robin session id allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sidalloc_pkg;

  // table geometry
  localparam int SESSION_SLOTS = 1024;
  localparam int SLOT_W        = (SESSION_SLOTS > 1) ? $clog2(SESSION_SLOTS) : 1;
  localparam int SID_W         = 16;
  localparam int MAC_W         = 48;
  localparam int GID_W         = 10;
  localparam int STATUS_W      = 3;
  localparam int CMD_W         = 2;

  // command codes
  localparam logic [CMD_W-1:0] CMD_ALLOC     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TERMINATE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RELEASE   = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_ALLOCATED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL       = 3'd1;
  localparam logic [STATUS_W-1:0] ST_TERMINATED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_IGNORED    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RELEASED   = 3'd4;

  // request and result payloads
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [SID_W-1:0] session_id;
    logic [MAC_W-1:0] peer_mac;
  } in_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [GID_W-1:0]    given_id;
  } out_res_t;

  // one slot of the table
  typedef struct packed {
    logic             occ;
    logic [MAC_W-1:0] mac;
  } entry_t;

  // memory access from the sequencer
  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    entry_t            wdata;
    logic [SLOT_W-1:0] raddr;
  } mem_req_t;

  // sequencer states
  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_LOOKUP
  } state_t;

endpackage

`default_nettype wire

### hw/rtl/sidalloc_ram.sv
// ----------------------------------------------------------------------------
// sidalloc_ram
// Slot table: occupied mark and peer MAC per slot, one write and one
// registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sidalloc_ram (
  input  wire                     clk,
  input  sidalloc_pkg::mem_req_t  mem_req,
  output sidalloc_pkg::entry_t    rd_data
);
  import sidalloc_pkg::*;

  entry_t mem [SESSION_SLOTS];
  entry_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      mem[mem_req.waddr] <= mem_req.wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem[mem_req.raddr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

### hw/rtl/sidalloc_seq.sv
// ----------------------------------------------------------------------------
// sidalloc_seq
// Sequencer: clearing pass, round-robin free-slot scan through one shared
// compare and increment unit, terminate and release handling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sidalloc_seq (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      start,
  input  sidalloc_pkg::in_req_t    in_req,
  input  sidalloc_pkg::entry_t     rd_data,
  output sidalloc_pkg::mem_req_t   mem_req,
  output logic                     busy,
  output logic                     out_valid,
  output sidalloc_pkg::out_res_t   out_res
);
  import sidalloc_pkg::*;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SESSION_SLOTS - 1);
  localparam logic [SLOT_W-1:0] SCAN_END  = SLOT_W'(SESSION_SLOTS - 2);
  localparam logic [SID_W:0]    SID_LIM   = (SID_W + 1)'(SESSION_SLOTS);

  // round-robin successor, wrapping to slot 1
  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] c);
    return (c == LAST_SLOT) ? SLOT_W'(1) : c + SLOT_W'(1);
  endfunction

  state_t            state_r, state_nxt;
  logic [SLOT_W-1:0] clr_idx_r, clr_idx_nxt;
  logic [SLOT_W-1:0] chk_r, chk_nxt;
  logic [SLOT_W-1:0] cnt_r, cnt_nxt;
  logic [SLOT_W-1:0] last_given_r, last_given_nxt;
  logic [MAC_W-1:0]  mac_r, mac_nxt;
  logic [SLOT_W-1:0] sid_r, sid_nxt;
  logic              in_range_r, in_range_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_res_t          out_res_r, out_res_nxt;

  logic              in_range;
  logic [SLOT_W-1:0] sid_idx;
  logic [SLOT_W-1:0] first_slot;

  assign in_range   = {1'b0, in_req.session_id} < SID_LIM;
  assign sid_idx    = in_req.session_id[SLOT_W-1:0];
  assign first_slot = next_slot(last_given_r);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_idx_r    <= '0;
      last_given_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_idx_r    <= clr_idx_nxt;
      last_given_r <= last_given_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    chk_r      <= chk_nxt;
    cnt_r      <= cnt_nxt;
    mac_r      <= mac_nxt;
    sid_r      <= sid_nxt;
    in_range_r <= in_range_nxt;
    out_res_r  <= out_res_nxt;
  end

  // next state, memory access and result
  always_comb begin
    state_nxt      = state_r;
    clr_idx_nxt    = clr_idx_r;
    chk_nxt        = chk_r;
    cnt_nxt        = cnt_r;
    last_given_nxt = last_given_r;
    mac_nxt        = mac_r;
    sid_nxt        = sid_r;
    in_range_nxt   = in_range_r;
    out_valid_nxt  = 1'b0;
    out_res_nxt    = out_res_r;
    mem_req        = '0;
    mem_req.raddr  = sid_idx;

    case (state_r)
      // wipe occupied marks after reset
      S_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = clr_idx_r;
        mem_req.wdata = '0;
        clr_idx_nxt   = clr_idx_r + SLOT_W'(1);
        if (clr_idx_r == LAST_SLOT) begin
          state_nxt = S_IDLE;
        end
      end

      // take a request
      S_IDLE: begin
        if (start) begin
          mac_nxt      = in_req.peer_mac;
          sid_nxt      = sid_idx;
          in_range_nxt = in_range;
          case (in_req.cmd)
            CMD_ALLOC: begin
              mem_req.raddr = first_slot;
              chk_nxt       = first_slot;
              cnt_nxt       = '0;
              state_nxt     = S_SCAN;
            end
            CMD_TERMINATE: begin
              mem_req.raddr = sid_idx;
              state_nxt     = S_LOOKUP;
            end
            CMD_RELEASE: begin
              mem_req.we    = in_range;
              mem_req.waddr = sid_idx;
              mem_req.wdata = '0;
              out_valid_nxt = 1'b1;
              out_res_nxt   = '{status: ST_RELEASED, given_id: '0};
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_res_nxt   = '{status: ST_IGNORED, given_id: '0};
            end
          endcase
        end
      end

      // one candidate slot per cycle, read of the next one in flight
      S_SCAN: begin
        mem_req.raddr = next_slot(chk_r);
        if (chk_r == last_given_r) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = '{status: ST_FULL, given_id: '0};
          state_nxt     = S_IDLE;
        end else if (!rd_data.occ) begin
          mem_req.we     = 1'b1;
          mem_req.waddr  = chk_r;
          mem_req.wdata  = '{occ: 1'b1, mac: mac_r};
          last_given_nxt = chk_r;
          out_valid_nxt  = 1'b1;
          out_res_nxt    = '{status: ST_ALLOCATED, given_id: GID_W'(chk_r)};
          state_nxt      = S_IDLE;
        end else if (cnt_r == SCAN_END) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = '{status: ST_FULL, given_id: '0};
          state_nxt     = S_IDLE;
        end else begin
          chk_nxt = next_slot(chk_r);
          cnt_nxt = cnt_r + SLOT_W'(1);
        end
      end

      // terminate: free only on an occupied slot with matching mac
      S_LOOKUP: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
        if (in_range_r && rd_data.occ && (rd_data.mac == mac_r)) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = sid_r;
          mem_req.wdata = '0;
          out_res_nxt   = '{status: ST_TERMINATED, given_id: '0};
        end else begin
          out_res_nxt   = '{status: ST_IGNORED, given_id: '0};
        end
      end

      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

`default_nettype wire

### hw/rtl/session_id_allocator_core.sv
// ----------------------------------------------------------------------------
// session_id_allocator_core
// Round-robin session id allocator with per-slot peer MAC check.
// ----------------------------------------------------------------------------
// Usage:
//   A request (in_req: cmd, session_id, peer_mac) is taken at a rising edge
//   with start high and busy low. Each request gives exactly one result on
//   out_res, shown for one cycle with out_valid high; the receiver cannot
//   stall it, so it must take the result in that cycle.
//   Work between the accepting edge and the result:
//     release or unused command  result registered directly
//     terminate                  one registered table read
//     allocate                   slots examined: from 1 to
//                                SESSION_SLOTS - 1; the scan examines one
//                                slot per cycle through the single table
//                                read port, with the next read overlapped
//   busy is high while a scan or lookup runs and drops with the result;
//   release and unused commands never raise it. A new request may be
//   taken at the edge that takes the previous result.
//   After reset the table is cleared one slot per cycle, all SESSION_SLOTS
//   (1024) slots, with busy high; the last-given slot resets to zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module session_id_allocator_core (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      start,
  output logic                     busy,
  input  sidalloc_pkg::in_req_t    in_req,
  output logic                     out_valid,
  output sidalloc_pkg::out_res_t   out_res
);
  import sidalloc_pkg::*;

  mem_req_t mem_req;
  entry_t   rd_data;

  // sequencer
  sidalloc_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_req    (in_req),
    .rd_data   (rd_data),
    .mem_req   (mem_req),
    .busy      (busy),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  // slot table
  sidalloc_ram u_ram (
    .clk     (clk),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

endmodule

`default_nettype wire

### hw/rtl/sidalloc_checker.sv
// ----------------------------------------------------------------------------
// sidalloc_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sidalloc_checker (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      start,
  input  wire                      busy,
  input  sidalloc_pkg::in_req_t    in_req,
  input  wire                      out_valid,
  input  sidalloc_pkg::out_res_t   out_res
);
  import sidalloc_pkg::*;

  // a taken request is either answered at once or keeps the block busy
  a_req_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_valid || busy))
    else $error("request neither answered nor in progress");

  // results only come out while the block is ready again
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  // an allocation never hands out slot zero
  a_alloc_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_res.status == ST_ALLOCATED)) |-> (out_res.given_id != '0))
    else $error("slot zero handed out");

  // given id is zero for every other status
  a_gid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_res.status != ST_ALLOCATED)) |-> (out_res.given_id == '0))
    else $error("given id set without allocation");

  // an immediate answer is a release or an ignored command
  a_fast_status: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) ##1 out_valid |->
      ((out_res.status == ST_RELEASED) || (out_res.status == ST_IGNORED)))
    else $error("unexpected status one cycle after request");

endmodule

bind session_id_allocator_core sidalloc_checker u_sidalloc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_req    (in_req),
  .out_valid (out_valid),
  .out_res   (out_res)
);

`default_nettype wire
